// File: design/idl_pkg.sv
// types and codes shared by the indexed list insert/delete unit
// no dependencies; imported by indexed_list_insert_delete_unit
`timescale 1ns / 1ps

package idl_pkg;

  // command codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_NEG   = 3'd1,
    STAT_OOB   = 3'd2,
    STAT_EMPTY = 3'd3,
    STAT_FULL  = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_DELETE,
    S_READ
  } state_e;

  // one command item
  typedef struct packed {
    op_e                op;
    logic signed [7:0]  position;
    logic signed [31:0] value;
  } cmd_t;

  // one result item
  typedef struct packed {
    status_e            status;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
  } rsp_t;

endpackage

// File: design/indexed_list_insert_delete_unit.sv
// positional list of signed 32-bit values kept in a single-port-write memory
// depends on idl_pkg
`timescale 1ns / 1ps

// Usage
//   command channel: cmd_i is taken at a rising edge where start is high and
//   busy is low. Commands: append, insert at position, delete at position,
//   read at position. Errors (negative position, out of bounds, empty, full)
//   leave the list unchanged.
//   result channel: done_o pulses for one cycle with rsp_o (status, value read,
//   entry count after the command). The receiver cannot stall; each item gives
//   exactly one result.
//   the result appears in the cycle after the item's last busy cycle.
//   Append and any rejected command finish without entering a busy state;
//   read issues one memory read and returns the registered read data;
//   insert moves the entries from the position up, top first, then writes
//   the new value; delete moves the entries above the position down, bottom
//   first. Each moved entry is read while the previous one is written back,
//   and the last write is drained before the final update.
//   throughput: busy is low again in the result cycle, so the next item can be
//   taken at the edge that ends it; appends and rejects go back to back.
//   reset: clears the entry count and the sequencer; the memory contents are
//   left as they are and are never read before being written.
module indexed_list_insert_delete_unit #(
  parameter int CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  idl_pkg::cmd_t cmd_i,
  output logic          done_o,
  output idl_pkg::rsp_t rsp_o
);

  import idl_pkg::*;

  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int PosW  = 7;
  localparam int CmpW  = (CntW > PosW) ? CntW : PosW;

  // list storage
  logic [31:0] mem_q [CAPACITY];
  logic [31:0] rd_data_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic [AddrW-1:0] mem_raddr;

  // sequencer and bookkeeping
  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  cur_q, cur_d;
  logic             wr_pend_q, wr_pend_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic [CmpW-1:0]  pos_q, pos_d;
  logic [31:0]      val_q, val_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic            pos_neg;
  logic            list_full;
  status_e         cmd_status;

  assign pos_neg   = cmd_i.position[7];
  assign pos_ext   = CmpW'(cmd_i.position[PosW-1:0]);
  assign cnt_ext   = CmpW'(count_q);
  assign list_full = (count_q == CntW'(CAPACITY));

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // command checks: negative position first; delete tests empty before bounds
  always_comb begin
    cmd_status = STAT_OK;
    unique case (cmd_i.op)
      OP_APPEND: begin
        if (list_full) cmd_status = STAT_FULL;
      end
      OP_INSERT: begin
        if (pos_neg)                cmd_status = STAT_NEG;
        else if (pos_ext > cnt_ext) cmd_status = STAT_OOB;
        else if (list_full)         cmd_status = STAT_FULL;
      end
      OP_DELETE: begin
        if (pos_neg)                 cmd_status = STAT_NEG;
        else if (count_q == '0)      cmd_status = STAT_EMPTY;
        else if (pos_ext >= cnt_ext) cmd_status = STAT_OOB;
      end
      OP_READ: begin
        if (pos_neg)                 cmd_status = STAT_NEG;
        else if (pos_ext >= cnt_ext) cmd_status = STAT_OOB;
      end
      default: cmd_status = STAT_OK;
    endcase
  end

  // next state, memory access and result
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cur_d     = cur_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    pos_d     = pos_q;
    val_d     = val_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = rd_data_q;
    mem_raddr = AddrW'(cur_q);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          pos_d = pos_ext;
          val_d = cmd_i.value;
          rsp_d.status      = cmd_status;
          rsp_d.read_value  = '0;
          rsp_d.entry_count = 5'(count_q);
          if (cmd_status != STAT_OK) begin
            done_d = 1'b1;
          end else begin
            unique case (cmd_i.op)
              OP_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = AddrW'(count_q);
                mem_wdata = cmd_i.value;
                count_d   = count_q + CntW'(1);
                rsp_d.entry_count = 5'(count_d);
                done_d    = 1'b1;
              end
              OP_INSERT: begin
                cur_d   = count_q;
                state_d = S_INSERT;
              end
              OP_DELETE: begin
                cur_d   = CntW'(pos_ext) + CntW'(1);
                state_d = S_DELETE;
              end
              OP_READ: begin
                mem_raddr = AddrW'(pos_ext);
                state_d   = S_READ;
              end
              default: state_d = S_IDLE;
            endcase
          end
        end
      end

      // move entries up one slot, top first, then write the new value
      S_INSERT: begin
        if (wr_pend_q) begin
          mem_we = 1'b1;
        end
        if (CmpW'(cur_q) > pos_q) begin
          mem_raddr = AddrW'(cur_q - CntW'(1));
          wr_pend_d = 1'b1;
          wr_addr_d = AddrW'(cur_q);
          cur_d     = cur_q - CntW'(1);
        end else if (!wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = AddrW'(pos_q);
          mem_wdata = val_q;
          count_d   = count_q + CntW'(1);
          rsp_d.entry_count = 5'(count_d);
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end

      // move entries above the position down one slot, bottom first
      S_DELETE: begin
        if (wr_pend_q) begin
          mem_we = 1'b1;
        end
        if (cur_q < count_q) begin
          mem_raddr = AddrW'(cur_q);
          wr_pend_d = 1'b1;
          wr_addr_d = AddrW'(cur_q - CntW'(1));
          cur_d     = cur_q + CntW'(1);
        end else if (!wr_pend_q) begin
          count_d   = count_q - CntW'(1);
          rsp_d.entry_count = 5'(count_d);
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end

      // read data is registered; it arrives in the cycle after the address
      S_READ: begin
        rsp_d.read_value = rd_data_q;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      wr_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      wr_pend_q <= wr_pend_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    wr_addr_q <= wr_addr_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    rsp_q     <= rsp_d;
  end

endmodule
